// ===== rtl/core/msb_pkg.sv =====
// Shared types and constants of the minimum-speed throttle boost block.
`timescale 1ns / 1ps
`default_nettype none
package msb_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 16;
    localparam int TMO_W    = 22;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 9;
    localparam int ACC_W    = 25;    // Q9.16 accumulator
    localparam int FRAC_W   = 16;
    localparam int BOOST_W  = 9;

    // Configuration port
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;

    typedef enum logic [2:0] {
        REG_TIMEOUT  = 3'd0,
        REG_TARGET   = 3'd1,
        REG_DEADBAND = 3'd2,
        REG_GAIN     = 3'd3,
        REG_LIMIT    = 3'd4
    } t_reg_idx;

    localparam logic [TMO_W-1:0]   RST_TIMEOUT  = 22'd500000;
    localparam logic [SPEED_W-1:0] RST_TARGET   = 16'd700;
    localparam logic [SPEED_W-1:0] RST_DEADBAND = 16'd50;
    localparam logic [GAIN_W-1:0]  RST_GAIN     = 16'd384;
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = 9'd500;

    // Multiplier and constant divider
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DVD_W    = 62;    // |err| * gain * dt * 256
    localparam int Q_W      = 26;    // quotient bits produced by the divider
    localparam int INC_W    = Q_W + 1;
    localparam int HI_W     = DVD_W - Q_W;
    localparam int REM_W    = 20;    // remainder < 1e6
    localparam int TRIAL_W  = REM_W + 2;
    localparam int DIV_STEPS = Q_W / 2;
    localparam int DIV_CW   = $clog2(DIV_STEPS);
    localparam int SUM_W    = INC_W;

    localparam logic [TRIAL_W-1:0] DIV_D1 = 22'd1000000;
    localparam logic [TRIAL_W-1:0] DIV_D2 = 22'd2000000;
    localparam logic [TRIAL_W-1:0] DIV_D3 = 22'd3000000;
    // Increment large enough to drive any accumulator to either rail
    localparam logic [INC_W-1:0]   INC_SAT = INC_W'(1) << Q_W;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
    } t_div_ctrl;

    typedef struct packed {
        logic             done;
        logic [INC_W-1:0] quotient;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== rtl/core/msb_in_if.sv =====
// Request channel carrying one controller call.
`timescale 1ns / 1ps
`default_nettype none
interface msb_in_if import msb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  time_us;
    logic [SPEED_W-1:0] ground_speed_cms;
    logic               position_valid;
    logic               position_new;

    modport source (
        output valid, time_us, ground_speed_cms, position_valid, position_new,
        input  ready
    );
    modport sink (
        input  valid, time_us, ground_speed_cms, position_valid, position_new,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/msb_out_if.sv =====
// Result channel carrying the boost and the sample-consumed flag.
`timescale 1ns / 1ps
`default_nettype none
interface msb_out_if import msb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BOOST_W-1:0] throttle_boost;
    logic               sample_consumed;

    modport source (
        output valid, throttle_boost, sample_consumed,
        input  ready
    );
    modport sink (
        input  valid, throttle_boost, sample_consumed,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/msb_mul.sv =====
// Registered 32x32 unsigned multiplier, shared by both product steps.
`timescale 1ns / 1ps
`default_nettype none
module msb_mul import msb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic      [PROD_W-1:0] o_p
);
    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== rtl/core/msb_div.sv =====
// Radix-4 divider by one million with saturation of oversized quotients.
`timescale 1ns / 1ps
`default_nettype none
module msb_div import msb_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_ctrl i_ctrl,
    output t_div_stat      o_stat
);
    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [DIV_CW-1:0]  r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [Q_W-1:0]     r_low;
    logic [Q_W-1:0]     r_q;

    logic [HI_W-1:0]    w_hi;
    logic [TRIAL_W-1:0] w_trial;
    logic [REM_W-1:0]   w_rem;
    logic [1:0]         w_digit;

    assign w_hi    = i_ctrl.dividend[DVD_W-1 -: HI_W];
    assign w_trial = {r_rem, r_low[Q_W-1 -: 2]};

    // one radix-4 digit: pick the largest multiple of the divisor that fits
    always_comb begin
        if (w_trial >= DIV_D3) begin
            w_digit = 2'd3;
            w_rem   = REM_W'(w_trial - DIV_D3);
        end else if (w_trial >= DIV_D2) begin
            w_digit = 2'd2;
            w_rem   = REM_W'(w_trial - DIV_D2);
        end else if (w_trial >= DIV_D1) begin
            w_digit = 2'd1;
            w_rem   = REM_W'(w_trial - DIV_D1);
        end else begin
            w_digit = 2'd0;
            w_rem   = w_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                if (w_hi >= HI_W'(DIV_D1)) begin
                    // quotient would not fit in 26 bits: saturate
                    r_sat  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_sat  <= 1'b0;
                    r_busy <= 1'b1;
                    r_cnt  <= DIV_CW'(DIV_STEPS - 1);
                    r_rem  <= w_hi[REM_W-1:0];
                    r_low  <= i_ctrl.dividend[Q_W-1:0];
                    r_q    <= '0;
                end
            end else if (r_busy) begin
                r_rem <= w_rem;
                r_low <= {r_low[Q_W-3:0], 2'b00};
                r_q   <= {r_q[Q_W-3:0], w_digit};
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_sat ? INC_SAT : {1'b0, r_q};
endmodule
`default_nettype wire

// ===== rtl/core/min_speed_throttle_boost_core.sv =====
// Top level: minimum-speed throttle boost, an integrating controller with deadband and clamp.
// Path: without integration a request passes PREP and EVAL, plus CLAMP inside the deadband,
//   before the result; an integrating request also passes the products, the 13-digit radix-4 divide and ACC.
// One request at a time: the next is taken in the cycle after the result is
//   taken, the divider setting the pace for integrating requests.
// Reset (synchronous, active low): registers to their defaults, timestamps and boost zero.
`timescale 1ns / 1ps
`default_nettype none
module min_speed_throttle_boost_core import msb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    msb_in_if.sink                 i_in,
    msb_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);
    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TMO_W-1:0]   r_timeout;
    logic [SPEED_W-1:0] r_target;
    logic [SPEED_W-1:0] r_deadband;
    logic [GAIN_W-1:0]  r_gain;
    logic [LIMIT_W-1:0] r_limit;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= RST_TIMEOUT;
            r_target   <= RST_TARGET;
            r_deadband <= RST_DEADBAND;
            r_gain     <= RST_GAIN;
            r_limit    <= RST_LIMIT;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_TIMEOUT:  r_timeout  <= pwdata[TMO_W-1:0];
                REG_TARGET:   r_target   <= pwdata[SPEED_W-1:0];
                REG_DEADBAND: r_deadband <= pwdata[SPEED_W-1:0];
                REG_GAIN:     r_gain     <= pwdata[GAIN_W-1:0];
                REG_LIMIT:    r_limit    <= pwdata[LIMIT_W-1:0];
                default: ;    // unmapped addresses are ignored
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TIMEOUT:  prdata = CFG_DW'(r_timeout);
            REG_TARGET:   prdata = CFG_DW'(r_target);
            REG_DEADBAND: prdata = CFG_DW'(r_deadband);
            REG_GAIN:     prdata = CFG_DW'(r_gain);
            REG_LIMIT:    prdata = CFG_DW'(r_limit);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // IDLE -> PREP (gaps, |err|) -> EVAL (timeout / flags / deadband)
    //   -> MUL1 (|err|*gain) -> MUL2 (*dt) -> DSTART -> DIV (/1e6)
    //   -> ACC (add or subtract, floor at 0) -> CLAMP (cap at limit) -> OUT; EVAL may skip to CLAMP or OUT
    // ------------------------------------------------------------------
    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_EVAL, S_MUL1, S_MUL2, S_DSTART, S_DIV, S_ACC, S_CLAMP, S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic               r_valid, n_valid;
    logic               r_fresh, n_fresh;
    logic [TIME_W-1:0]  r_gap, n_gap;        // time since previous call
    logic [TIME_W-1:0]  r_pgap, n_pgap;      // time since previous position sample
    logic [SPEED_W-1:0] r_mag, n_mag;        // |target - speed|
    logic               r_neg, n_neg;        // speed above target
    logic [TIME_W-1:0]  r_last_call, n_last_call;
    logic [TIME_W-1:0]  r_last_pos, n_last_pos;
    logic [ACC_W-1:0]   r_acc, n_acc;        // Q9.16 boost
    logic [SUM_W-1:0]   r_sum, n_sum;        // accumulator before the upper clamp
    logic               r_consumed, n_consumed;

    logic [SPEED_W:0]   w_err;
    logic [ACC_W-1:0]   w_top;
    logic               w_mul_en;
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    t_div_ctrl          w_div_ctrl;
    t_div_stat          w_div_stat;

    assign w_err = {1'b0, r_target} - {1'b0, r_speed};
    assign w_top = {r_limit, {FRAC_W{1'b0}}};

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_speed     = r_speed;
        n_valid     = r_valid;
        n_fresh     = r_fresh;
        n_gap       = r_gap;
        n_pgap      = r_pgap;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_last_call = r_last_call;
        n_last_pos  = r_last_pos;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_consumed  = r_consumed;
        w_mul_en    = 1'b0;
        w_mul_a     = MUL_W'(r_mag);
        w_mul_b     = MUL_W'(r_gain);
        w_div_ctrl.start    = 1'b0;
        w_div_ctrl.dividend = {w_prod[DVD_W-9:0], 8'h00};   // times 256

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_time  = i_in.time_us;
                    n_speed = i_in.ground_speed_cms;
                    n_valid = i_in.position_valid;
                    n_fresh = i_in.position_new;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_gap   = r_time - r_last_call;
                n_pgap  = r_time - r_last_pos;
                n_neg   = w_err[SPEED_W];
                n_mag   = w_err[SPEED_W] ? SPEED_W'(-w_err) : w_err[SPEED_W-1:0];
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_last_call = r_time;
                n_consumed  = 1'b0;
                n_state     = S_OUT;
                if (r_gap > TIME_W'(r_timeout)) begin
                    // call gap timed out: re-arm and clear
                    n_last_pos = r_time;
                    n_acc      = '0;
                end else if (!r_valid) begin
                    n_acc = '0;
                end else if (r_fresh) begin
                    n_last_pos = r_time;
                    n_consumed = 1'b1;
                    if (r_pgap >= TIME_W'(r_timeout)) begin
                        n_acc = '0;                 // stale sample
                    end else if (r_mag > r_deadband) begin
                        n_state = S_MUL1;
                    end else begin
                        n_sum   = SUM_W'(r_acc);    // inside deadband: clamp only
                        n_state = S_CLAMP;
                    end
                end
            end
            S_MUL1: begin
                w_mul_en = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                // pgap is below the 22-bit timeout here, so the product fits 54 bits
                w_mul_en = 1'b1;
                w_mul_a  = w_prod[MUL_W-1:0];
                w_mul_b  = r_pgap;
                n_state  = S_DSTART;
            end
            S_DSTART: begin
                w_div_ctrl.start = 1'b1;
                n_state          = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_neg) begin
                    n_sum = (w_div_stat.quotient > INC_W'(r_acc)) ? '0 :
                            INC_W'(r_acc) - w_div_stat.quotient;
                end else begin
                    n_sum = INC_W'(r_acc) + w_div_stat.quotient;
                end
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_acc   = (r_sum > SUM_W'(w_top)) ? w_top : r_sum[ACC_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_call <= '0;
            r_last_pos  <= '0;
            r_acc       <= '0;
        end else begin
            r_state     <= n_state;
            r_last_call <= n_last_call;
            r_last_pos  <= n_last_pos;
            r_acc       <= n_acc;
            r_time      <= n_time;
            r_speed     <= n_speed;
            r_valid     <= n_valid;
            r_fresh     <= n_fresh;
            r_gap       <= n_gap;
            r_pgap      <= n_pgap;
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_sum       <= n_sum;
            r_consumed  <= n_consumed;
        end
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units
    // ------------------------------------------------------------------
    msb_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    msb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .o_stat  (w_div_stat)
    );

    // ------------------------------------------------------------------
    // Handshake and result
    // ------------------------------------------------------------------
    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.throttle_boost  = r_acc[ACC_W-1 -: BOOST_W];
    assign o_out.sample_consumed = r_consumed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("request taken while a result is pending");

    // a held boost keeps its value even if the limit was lowered meanwhile
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.sample_consumed) |-> (r_acc <= w_top))
        else $error("boost above limit after a consumed sample");

    a_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.sample_consumed) |-> (r_valid && r_fresh))
        else $error("sample consumed without a new valid position");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && (r_gap > TIME_W'(r_timeout)))
            |=> ((r_acc == '0) && (r_state == S_OUT) && !r_consumed))
        else $error("call timeout did not clear the boost");

endmodule
`default_nettype wire
